// ===== rtl/node_registry_with_aging_assert.svh =====
`ifndef NODE_REGISTRY_WITH_AGING_ASSERT_SVH
`define NODE_REGISTRY_WITH_AGING_ASSERT_SVH

// same-cycle implication
`define NRA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nra assertion failed");

// next-cycle implication
`define NRA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nra assertion failed");

`endif

// ===== rtl/nra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package nra_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int RM_W     = 6;
  localparam logic [15:0] TIMEOUT_RESET = 16'd15;

  typedef enum logic [2:0] {
    MODE_ANNOUNCE = 3'd0,
    MODE_REFRESH  = 3'd1,
    MODE_LOOKUP   = 3'd2,
    MODE_TICK     = 3'd3,
    MODE_SWEEP    = 3'd4,
    MODE_LIST     = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    STAT_DONE     = 3'd0,
    STAT_INSERTED = 3'd1,
    STAT_UPDATED  = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_FULL     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [15:0] cpu;
    logic [7:0]  gpu;
    logic [31:0] mem;
    logic [31:0] heard;
    logic [31:0] order;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ===== rtl/nra_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/node_registry_with_aging.sv =====
// tick and unused modes give their item in the cycle after acceptance
// announce, refresh, lookup and sweep: a scan over every slot through the registered ram read, then the item
// list: one full scan per emitted entry, straight to the response state when empty
// one item at a time, next accepted the cycle after the last result is taken; the entry ram has a registered read port
// reset: valid bits and counters are cleared and timeout is set to 15 at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
`include "node_registry_with_aging_assert.svh"
module node_registry_with_aging (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [15:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // ip_address, port, cpu, gpu, mem
  input  wire logic [103:0] s_axis_tdata,
  // mode
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // removed_count, listed_ip, listed_port, listed_cpu, listed_mem, listed_gpu, zero fill
  output logic [111:0]      m_axis_tdata,
  // status, found, entry_present
  output logic [4:0]        m_axis_tuser,
  output logic              m_axis_tlast
);

  localparam int N  = nra_pkg::CAPACITY;
  localparam int IW = nra_pkg::IDX_W;
  localparam int CW = nra_pkg::CNT_W;
  localparam int RW = nra_pkg::RM_W;

  nra_pkg::state_e state_q, state_d;

  logic [2:0]  mode_q, mode_d;
  logic [31:0] ip_q, ip_d;
  logic [15:0] port_q, port_d;
  logic [15:0] cpu_q, cpu_d;
  logic [7:0]  gpu_q, gpu_d;
  logic [31:0] mem_q, mem_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          pv_q, pv_d;
  logic [IW-1:0] pidx_q, pidx_d;

  logic               hit_q, hit_d;
  logic [IW-1:0]      hit_idx_q, hit_idx_d;
  nra_pkg::entry_t    hit_ent_q, hit_ent_d;
  logic               free_q, free_d;
  logic [IW-1:0]      free_idx_q, free_idx_d;
  logic [RW-1:0]      removed_q, removed_d;

  logic               best_q, best_d;
  logic [31:0]        best_age_q, best_age_d;
  logic [IW-1:0]      best_idx_q, best_idx_d;
  nra_pkg::entry_t    best_ent_q, best_ent_d;
  logic [N-1:0]       taken_q, taken_d;
  logic [CW-1:0]      remain_q, remain_d;

  logic [N-1:0]  valid_q, valid_d;
  logic [CW-1:0] vcnt_q, vcnt_d;
  logic [31:0]   secs_q, secs_d;
  logic [31:0]   ins_q, ins_d;
  logic [15:0]   timeout_q;

  logic [2:0]      o_status_q, o_status_d;
  logic            o_found_q, o_found_d;
  logic [RW-1:0]   o_removed_q, o_removed_d;
  logic            o_present_q, o_present_d;
  nra_pkg::entry_t o_ent_q, o_ent_d;
  logic            o_last_q, o_last_d;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  nra_pkg::entry_t ram_wdata;
  logic [IW-1:0]   ram_raddr;
  nra_pkg::entry_t ram_rdata;

  logic        in_acc;
  logic        scan_done;
  logic [31:0] age;

  nra_ram #(
    .WIDTH (nra_pkg::ENTRY_W),
    .DEPTH (N)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == nra_pkg::ST_IDLE);
  assign m_axis_tvalid = (state_q == nra_pkg::ST_RESP);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign scan_done     = (cnt_q == CW'(N)) && !pv_q;
  assign age           = ins_q - ram_rdata.order;
  assign ram_raddr     = cnt_q[IW-1:0];

  assign m_axis_tdata = {2'b00, o_ent_q.gpu, o_ent_q.mem, o_ent_q.cpu, o_ent_q.port,
                         o_ent_q.addr, o_removed_q};
  assign m_axis_tuser = {o_present_q, o_found_q, o_status_q};
  assign m_axis_tlast = o_last_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      nra_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser)
            nra_pkg::MODE_ANNOUNCE, nra_pkg::MODE_REFRESH,
            nra_pkg::MODE_LOOKUP, nra_pkg::MODE_SWEEP: state_d = nra_pkg::ST_SCAN;
            nra_pkg::MODE_LIST: begin
              state_d = (vcnt_q == '0) ? nra_pkg::ST_RESP : nra_pkg::ST_SCAN;
            end
            default: state_d = nra_pkg::ST_RESP;
          endcase
        end
      end
      nra_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = nra_pkg::ST_RESP;
        end
      end
      nra_pkg::ST_RESP: begin
        if (m_axis_tready) begin
          if (mode_q == nra_pkg::MODE_LIST && remain_q > CW'(1)) begin
            state_d = nra_pkg::ST_SCAN;
          end else begin
            state_d = nra_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = nra_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mode_d      = mode_q;
    ip_d        = ip_q;
    port_d      = port_q;
    cpu_d       = cpu_q;
    gpu_d       = gpu_q;
    mem_d       = mem_q;
    cnt_d       = cnt_q;
    pv_d        = 1'b0;
    pidx_d      = pidx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_ent_d   = hit_ent_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    removed_d   = removed_q;
    best_d      = best_q;
    best_age_d  = best_age_q;
    best_idx_d  = best_idx_q;
    best_ent_d  = best_ent_q;
    taken_d     = taken_q;
    remain_d    = remain_q;
    valid_d     = valid_q;
    vcnt_d      = vcnt_q;
    secs_d      = secs_q;
    ins_d       = ins_q;
    o_status_d  = o_status_q;
    o_found_d   = o_found_q;
    o_removed_d = o_removed_q;
    o_present_d = o_present_q;
    o_ent_d     = o_ent_q;
    o_last_d    = o_last_q;
    ram_we      = 1'b0;
    ram_waddr   = hit_idx_q;
    ram_wdata   = hit_ent_q;

    case (state_q)
      nra_pkg::ST_IDLE: begin
        if (in_acc) begin
          mode_d      = s_axis_tuser;
          ip_d        = s_axis_tdata[31:0];
          port_d      = s_axis_tdata[47:32];
          cpu_d       = s_axis_tdata[63:48];
          gpu_d       = s_axis_tdata[71:64];
          mem_d       = s_axis_tdata[103:72];
          cnt_d       = '0;
          hit_d       = 1'b0;
          free_d      = 1'b0;
          removed_d   = '0;
          best_d      = 1'b0;
          taken_d     = '0;
          remain_d    = vcnt_q;
          o_status_d  = nra_pkg::STAT_DONE;
          o_found_d   = 1'b0;
          o_removed_d = '0;
          o_present_d = 1'b0;
          o_ent_d     = '0;
          o_last_d    = 1'b1;
          if (s_axis_tuser == nra_pkg::MODE_TICK) begin
            secs_d = secs_q + 32'd1;
          end
        end
      end
      nra_pkg::ST_SCAN: begin
        if (cnt_q != CW'(N)) begin
          pv_d   = 1'b1;
          pidx_d = cnt_q[IW-1:0];
          cnt_d  = cnt_q + CW'(1);
        end
        if (pv_q) begin
          case (mode_q)
            nra_pkg::MODE_ANNOUNCE, nra_pkg::MODE_REFRESH, nra_pkg::MODE_LOOKUP: begin
              if (valid_q[pidx_q] && !hit_q && ram_rdata.addr == ip_q &&
                  ram_rdata.port == port_q) begin
                hit_d     = 1'b1;
                hit_idx_d = pidx_q;
                hit_ent_d = ram_rdata;
              end
              if (!valid_q[pidx_q] && !free_q) begin
                free_d     = 1'b1;
                free_idx_d = pidx_q;
              end
            end
            nra_pkg::MODE_SWEEP: begin
              if (valid_q[pidx_q] && (secs_q - ram_rdata.heard) >= {16'd0, timeout_q}) begin
                valid_d[pidx_q] = 1'b0;
                vcnt_d          = vcnt_q - CW'(1);
                if (removed_q != '1) begin
                  removed_d = removed_q + RW'(1);
                end
              end
            end
            nra_pkg::MODE_LIST: begin
              if (valid_q[pidx_q] && !taken_q[pidx_q] && (!best_q || age < best_age_q)) begin
                best_d     = 1'b1;
                best_age_d = age;
                best_idx_d = pidx_q;
                best_ent_d = ram_rdata;
              end
            end
            default: ;
          endcase
        end
        if (scan_done) begin
          case (mode_q)
            nra_pkg::MODE_ANNOUNCE: begin
              if (hit_q) begin
                ram_we          = 1'b1;
                ram_waddr       = hit_idx_q;
                ram_wdata       = hit_ent_q;
                ram_wdata.cpu   = cpu_q;
                ram_wdata.gpu   = gpu_q;
                ram_wdata.mem   = mem_q;
                ram_wdata.heard = secs_q;
                o_status_d      = nra_pkg::STAT_UPDATED;
                o_found_d       = 1'b1;
              end else if (free_q) begin
                ram_we              = 1'b1;
                ram_waddr           = free_idx_q;
                ram_wdata.addr      = ip_q;
                ram_wdata.port      = port_q;
                ram_wdata.cpu       = cpu_q;
                ram_wdata.gpu       = gpu_q;
                ram_wdata.mem       = mem_q;
                ram_wdata.heard     = secs_q;
                ram_wdata.order     = ins_q;
                valid_d[free_idx_q] = 1'b1;
                vcnt_d              = vcnt_q + CW'(1);
                ins_d               = ins_q + 32'd1;
                o_status_d          = nra_pkg::STAT_INSERTED;
              end else begin
                o_status_d = nra_pkg::STAT_FULL;
              end
            end
            nra_pkg::MODE_REFRESH: begin
              if (hit_q) begin
                ram_we          = 1'b1;
                ram_waddr       = hit_idx_q;
                ram_wdata       = hit_ent_q;
                ram_wdata.heard = secs_q;
                o_status_d      = nra_pkg::STAT_UPDATED;
                o_found_d       = 1'b1;
              end else begin
                o_status_d = nra_pkg::STAT_NOTFOUND;
              end
            end
            nra_pkg::MODE_LOOKUP: begin
              o_status_d = hit_q ? nra_pkg::STAT_DONE : nra_pkg::STAT_NOTFOUND;
              o_found_d  = hit_q;
            end
            nra_pkg::MODE_SWEEP: begin
              o_removed_d = removed_q;
            end
            nra_pkg::MODE_LIST: begin
              o_present_d         = 1'b1;
              o_ent_d             = best_ent_q;
              o_last_d            = (remain_q == CW'(1));
              taken_d[best_idx_q] = 1'b1;
            end
            default: ;
          endcase
        end
      end
      nra_pkg::ST_RESP: begin
        if (m_axis_tready) begin
          cnt_d    = '0;
          best_d   = 1'b0;
          remain_d = remain_q - CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nra_pkg::ST_IDLE;
      cnt_q     <= '0;
      pv_q      <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      best_q    <= 1'b0;
      taken_q   <= '0;
      remain_q  <= '0;
      removed_q <= '0;
      valid_q   <= '0;
      vcnt_q    <= '0;
      secs_q    <= '0;
      ins_q     <= '0;
      timeout_q <= nra_pkg::TIMEOUT_RESET;
      mode_q    <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pv_q      <= pv_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      best_q    <= best_d;
      taken_q   <= taken_d;
      remain_q  <= remain_d;
      removed_q <= removed_d;
      valid_q   <= valid_d;
      vcnt_q    <= vcnt_d;
      secs_q    <= secs_d;
      ins_q     <= ins_d;
      mode_q    <= mode_d;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ip_q        <= ip_d;
    port_q      <= port_d;
    cpu_q       <= cpu_d;
    gpu_q       <= gpu_d;
    mem_q       <= mem_d;
    pidx_q      <= pidx_d;
    hit_idx_q   <= hit_idx_d;
    hit_ent_q   <= hit_ent_d;
    free_idx_q  <= free_idx_d;
    best_age_q  <= best_age_d;
    best_idx_q  <= best_idx_d;
    best_ent_q  <= best_ent_d;
    o_status_q  <= o_status_d;
    o_found_q   <= o_found_d;
    o_removed_q <= o_removed_d;
    o_present_q <= o_present_d;
    o_ent_q     <= o_ent_d;
    o_last_q    <= o_last_d;
  end

  `NRA_ASSERT_NOW(a_one_side, m_axis_tvalid, !s_axis_tready)
  `NRA_ASSERT_NOW(a_vcnt, 1'b1, vcnt_q == CW'($countones(valid_q)))
  `NRA_ASSERT_NOW(a_taken_valid, 1'b1, (taken_q & ~valid_q) == '0)
  `NRA_ASSERT_NEXT(a_ram_idle, state_q != nra_pkg::ST_SCAN, !ram_we)

endmodule
`default_nettype wire
